[sv/crcfr_pkg.sv]
// Package for the CRC-framed command receiver: constants, controller state type,
// the control and status structs between the controller and the datapath, and the CRC byte step.
// No dependencies.
`default_nettype none

package crcfr_pkg;

  // Frame layout
  localparam int          FRAME_LEN_I = 8;
  localparam int          FIDX_W      = $clog2(FRAME_LEN_I);
  localparam int          CNT_W       = $clog2(FRAME_LEN_I + 1);
  localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(FRAME_LEN_I);
  localparam int          CRC_LEN     = 6;
  localparam logic [FIDX_W-1:0] CRC_LAST = FIDX_W'(CRC_LEN - 1);
  localparam logic [FIDX_W-1:0] BYTE_WORD_HI = FIDX_W'(0);
  localparam logic [FIDX_W-1:0] BYTE_WORD_LO = FIDX_W'(1);
  localparam logic [FIDX_W-1:0] BYTE_RUN     = FIDX_W'(2);
  localparam logic [FIDX_W-1:0] BYTE_CRC_LO  = FIDX_W'(6);
  localparam logic [FIDX_W-1:0] BYTE_CRC_HI  = FIDX_W'(7);

  // CRC-16, reflected
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Run command codes in frame byte 2
  localparam logic [7:0] RUN_ON  = 8'h01;
  localparam logic [7:0] RUN_OFF = 8'h00;

  // Item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration
  localparam int          POLE_W      = 7;
  localparam int          SPEED_W     = 16;
  localparam int          PROD_W      = SPEED_W + POLE_W;
  localparam logic [POLE_W-1:0]  POLE_RESET  = 7'd2;
  localparam logic [SPEED_W-1:0] LIMIT_RESET = 16'd3500;
  localparam int          PADDR_W     = 3;
  localparam int          PDATA_W     = 32;
  // register index is paddr[2]
  localparam logic REG_POLE_COUNT  = 1'b0;
  localparam logic REG_SPEED_LIMIT = 1'b1;

  typedef struct packed {
    logic [POLE_W-1:0]  pole_count;
    logic [SPEED_W-1:0] speed_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic take_item;  // input transfer this cycle
    logic crc_init;   // preset CRC and byte index
    logic crc_step;   // fold one stored byte into the CRC
    logic finish;     // apply frame and load result register
  } dp_cmd_t;

  typedef struct packed {
    logic check_needed; // the offered tick triggers a frame check
    logic crc_last;     // last CRC byte is being folded
  } dp_sts_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/crcfr_in_if.sv]
// Input channel of the frame receiver: valid/ready with item kind and data byte.
// Depends on nothing.
`default_nettype none

interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

[sv/crcfr_out_if.sv]
// Result channel of the frame receiver: valid/ready with check outcome and drive commands.
// Depends on nothing.
`default_nettype none

interface crcfr_out_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic        run_command;
  logic [15:0] speed_reference;

  modport source (output valid, output crc_ok, output run_command, output speed_reference,
                  input ready);
  modport sink   (input valid, input crc_ok, input run_command, input speed_reference,
                  output ready);
endinterface

`default_nettype wire

[sv/crc_framed_command_receiver_unit.sv]
// Top level of the CRC-framed command receiver: configuration registers, controller, datapath.
// Depends on crcfr_pkg, crcfr_in_if, crcfr_out_if, crcfr_regs, crcfr_ctrl, crcfr_dp.
//
//   channel  dir  handshake               payload
//   in_if    in   valid/ready             op, rx_byte
//   out_if   out  valid/ready             crc_ok, run_command, speed_reference
//   apb      in   psel/penable/pwrite     paddr, pwdata -> prdata (pready tied high)
//
// A byte or a tick that checks nothing is taken in the idle state; the next item is taken next cycle.
// A tick that checks a full frame is handled in steps: accept, six CRC byte steps (one stored
// byte folded per cycle), then verdict and result load; the product is registered in the walk.
// The result register frees the input side: only a verdict that finds it still full waits.
// rst_n is synchronous; counters, run flag, speed and registers reset, the frame store does not.
`default_nettype none

module crc_framed_command_receiver_unit #(
  parameter int IDLE_SATURATE = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  crcfr_in_if.sink                           in_if,
  crcfr_out_if.source                        out_if,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crcfr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [crcfr_pkg::PDATA_W-1:0] pwdata,
  output      logic [crcfr_pkg::PDATA_W-1:0] prdata,
  output      logic                          pready
);

  crcfr_pkg::cfg_t    cfg;
  crcfr_pkg::dp_cmd_t cmd;
  crcfr_pkg::dp_sts_t sts;

  crcfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crcfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crcfr_dp #(
    .IDLE_SATURATE (IDLE_SATURATE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg                 (cfg),
    .in_op               (in_if.op),
    .in_rx_byte          (in_if.rx_byte),
    .out_crc_ok          (out_if.crc_ok),
    .out_run_command     (out_if.run_command),
    .out_speed_reference (out_if.speed_reference)
  );

endmodule

`default_nettype wire

[sv/crcfr_regs.sv]
// APB-style configuration registers: pole count and speed limit.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crcfr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [crcfr_pkg::PDATA_W-1:0] pwdata,
  output      logic [crcfr_pkg::PDATA_W-1:0] prdata,
  output      logic                          pready,
  output      crcfr_pkg::cfg_t               cfg
);

  crcfr_pkg::cfg_t cfg_r, cfg_nxt;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        crcfr_pkg::REG_POLE_COUNT:  cfg_nxt.pole_count  = pwdata[crcfr_pkg::POLE_W-1:0];
        crcfr_pkg::REG_SPEED_LIMIT: cfg_nxt.speed_limit = pwdata[crcfr_pkg::SPEED_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      crcfr_pkg::REG_POLE_COUNT:
        prdata = {{(crcfr_pkg::PDATA_W-crcfr_pkg::POLE_W){1'b0}}, cfg_r.pole_count};
      crcfr_pkg::REG_SPEED_LIMIT:
        prdata = {{(crcfr_pkg::PDATA_W-crcfr_pkg::SPEED_W){1'b0}}, cfg_r.speed_limit};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pole_count  <= crcfr_pkg::POLE_RESET;
      cfg_r.speed_limit <= crcfr_pkg::LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/crcfr_ctrl.sv]
// Controller of the frame receiver: sequences input transfer, CRC walk and result load,
// and owns the result valid flag. Depends on crcfr_pkg.
`default_nettype none

module crcfr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  output      logic               out_valid,
  input  wire logic               out_ready,
  input  wire crcfr_pkg::dp_sts_t sts,
  output      crcfr_pkg::dp_cmd_t cmd
);

  crcfr_pkg::ctrl_state_t state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      crcfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (sts.check_needed) begin
            cmd.crc_init = 1'b1;
            state_nxt    = crcfr_pkg::ST_CRC;
          end
        end
      end
      crcfr_pkg::ST_CRC: begin
        cmd.crc_step = 1'b1;
        if (sts.crc_last) begin
          state_nxt = crcfr_pkg::ST_DONE;
        end
      end
      crcfr_pkg::ST_DONE: begin
        // hold the verdict until the result register can take it
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = crcfr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = crcfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crcfr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transfer");

  a_init_to_crc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.crc_init |=> (state_r == crcfr_pkg::ST_CRC))
    else $error("check start did not enter CRC walk");

  a_crc_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == crcfr_pkg::ST_CRC && sts.crc_last) |=> (state_r == crcfr_pkg::ST_DONE))
    else $error("CRC walk did not end on its last byte");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != crcfr_pkg::ST_IDLE) |-> !cmd.take_item)
    else $error("item taken during a frame check");

endmodule

`default_nettype wire

[sv/crcfr_dp.sv]
// Datapath of the frame receiver: frame store, byte and idle counters, CRC register,
// speed product, run/speed state and result register. Depends on crcfr_pkg.
`default_nettype none

module crcfr_dp #(
  parameter int IDLE_SATURATE = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire crcfr_pkg::dp_cmd_t             cmd,
  output      crcfr_pkg::dp_sts_t             sts,
  input  wire crcfr_pkg::cfg_t                cfg,
  input  wire logic                           in_op,
  input  wire logic [7:0]                     in_rx_byte,
  output      logic                           out_crc_ok,
  output      logic                           out_run_command,
  output      logic [crcfr_pkg::SPEED_W-1:0]  out_speed_reference
);

  localparam int IDLE_W = $clog2(IDLE_SATURATE + 1);
  localparam logic [IDLE_W-1:0] IDLE_SAT = IDLE_W'(IDLE_SATURATE);
  localparam logic [IDLE_W-1:0] IDLE_ONE = IDLE_W'(1);
  localparam int QPROD_W = crcfr_pkg::PROD_W - 1;
  localparam logic [crcfr_pkg::CNT_W-1:0]  CNT_ONE = {{(crcfr_pkg::CNT_W-1){1'b0}}, 1'b1};
  localparam logic [crcfr_pkg::FIDX_W-1:0] IDX_ONE = {{(crcfr_pkg::FIDX_W-1){1'b0}}, 1'b1};

  logic [7:0]                    store_r [crcfr_pkg::FRAME_LEN_I];
  logic [crcfr_pkg::CNT_W-1:0]   byte_count_r, byte_count_nxt;
  logic [crcfr_pkg::CNT_W-1:0]   calt_r, calt_nxt;
  logic [IDLE_W-1:0]             idle_r, idle_nxt, idle_adv;
  logic                          store_we;
  logic [15:0]                   crc_r;
  logic [crcfr_pkg::FIDX_W-1:0]  idx_r;
  logic [QPROD_W-1:0]            prod_r;
  logic [crcfr_pkg::PROD_W-1:0]  prod_full;
  logic                          run_r, run_nxt;
  logic [crcfr_pkg::SPEED_W-1:0] speed_r, speed_nxt, speed_sat;
  logic                          crc_ok;
  logic                          out_crc_ok_r;
  logic                          out_run_r;
  logic [crcfr_pkg::SPEED_W-1:0] out_speed_r;

  // Tick bookkeeping
  always_comb begin
    if (byte_count_r == calt_r && idle_r < IDLE_SAT) begin
      idle_adv = idle_r + IDLE_ONE;
    end else begin
      idle_adv = idle_r;
    end
  end

  assign sts.check_needed = (in_op == crcfr_pkg::OP_TICK) &&
                            (byte_count_r == crcfr_pkg::FRAME_LEN) && (idle_adv == '0);
  assign sts.crc_last     = (idx_r == crcfr_pkg::CRC_LAST);

  always_comb begin
    byte_count_nxt = byte_count_r;
    calt_nxt       = calt_r;
    idle_nxt       = idle_r;
    store_we       = 1'b0;
    if (cmd.take_item) begin
      if (in_op == crcfr_pkg::OP_BYTE) begin
        idle_nxt = '0;
        if (byte_count_r < crcfr_pkg::FRAME_LEN) begin
          store_we       = 1'b1;
          byte_count_nxt = byte_count_r + CNT_ONE;
        end
      end else if (byte_count_r == '0) begin
        idle_nxt = '0;
        calt_nxt = '0;
      end else if (byte_count_r < crcfr_pkg::FRAME_LEN && idle_adv <= IDLE_ONE) begin
        idle_nxt = idle_adv;
        calt_nxt = byte_count_r;
      end else begin
        // partial frame gone idle, or full frame (checked or not): drop it
        byte_count_nxt = '0;
        calt_nxt       = '0;
        idle_nxt       = '0;
      end
    end
  end

  // Frame verdict and applied state
  assign prod_full = {{crcfr_pkg::POLE_W{1'b0}}, store_r[crcfr_pkg::BYTE_WORD_HI],
                      store_r[crcfr_pkg::BYTE_WORD_LO]}
                   * {{crcfr_pkg::SPEED_W{1'b0}}, cfg.pole_count};

  assign crc_ok = (store_r[crcfr_pkg::BYTE_CRC_LO] == crc_r[7:0]) &&
                  (store_r[crcfr_pkg::BYTE_CRC_HI] == crc_r[15:8]);

  always_comb begin
    if (prod_r > {{(QPROD_W-crcfr_pkg::SPEED_W){1'b0}}, cfg.speed_limit}) begin
      speed_sat = cfg.speed_limit;
    end else begin
      speed_sat = prod_r[crcfr_pkg::SPEED_W-1:0];
    end
  end

  always_comb begin
    run_nxt   = run_r;
    speed_nxt = speed_r;
    if (cmd.finish && crc_ok) begin
      speed_nxt = speed_sat;
      if (store_r[crcfr_pkg::BYTE_RUN] == crcfr_pkg::RUN_ON) begin
        run_nxt = 1'b1;
      end else if (store_r[crcfr_pkg::BYTE_RUN] == crcfr_pkg::RUN_OFF) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      calt_r       <= '0;
      idle_r       <= '0;
      run_r        <= 1'b0;
      speed_r      <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      calt_r       <= calt_nxt;
      idle_r       <= idle_nxt;
      run_r        <= run_nxt;
      speed_r      <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item && store_we) begin
      store_r[byte_count_r[crcfr_pkg::FIDX_W-1:0]] <= in_rx_byte;
    end
    if (cmd.crc_init) begin
      crc_r <= crcfr_pkg::CRC_INIT;
      idx_r <= '0;
    end else if (cmd.crc_step) begin
      crc_r  <= crcfr_pkg::crc16_byte(crc_r, store_r[idx_r]);
      idx_r  <= idx_r + IDX_ONE;
      prod_r <= prod_full[crcfr_pkg::PROD_W-1:1];
    end
    if (cmd.finish) begin
      out_crc_ok_r <= crc_ok;
      out_run_r    <= run_nxt;
      out_speed_r  <= speed_nxt;
    end
  end

  assign out_crc_ok          = out_crc_ok_r;
  assign out_run_command     = out_run_r;
  assign out_speed_reference = out_speed_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= crcfr_pkg::FRAME_LEN)
    else $error("byte count past frame length");

  a_idle_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idle_r <= IDLE_SAT)
    else $error("idle count past saturation");

  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_run_r == run_r && out_speed_r == speed_r))
    else $error("result does not match applied state");

  a_check_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_item && sts.check_needed) |=> (byte_count_r == '0 && idle_r == '0))
    else $error("checked frame not reset");

endmodule

`default_nettype wire
